>>> sv/rfd_pkg.sv
// Shared types, constants and command decode for the response frame deframer.
// Used by rfd_ctrl, rfd_datapath and response_frame_deframer.
package rfd_pkg;

    // Header bytes
    localparam logic [7:0] SYNC1_BYTE = 8'hEE;
    localparam logic [7:0] SYNC2_BYTE = 8'hAA;
    localparam logic [7:0] ZERO_BYTE  = 8'h00;

    // Response commands
    localparam logic [7:0] CMD_POS1   = 8'h07;
    localparam logic [7:0] CMD_POS10  = 8'h09;
    localparam logic [7:0] CMD_VEL10  = 8'h0B;
    localparam logic [7:0] CMD_CUR10  = 8'h0A;
    localparam logic [7:0] CMD_SENSOR = 8'h11;
    localparam logic [7:0] CMD_ERROR  = 8'h0D;
    localparam logic [7:0] CMD_TEMP   = 8'h0C;
    localparam logic [7:0] CMD_VENDOR = 8'hCD;

    // Body bytes kept, counted from frame offset 6
    localparam int BODY_KEEP = 32;
    localparam int BODY_AW   = $clog2(BODY_KEEP);

    // Frame offsets
    localparam logic [8:0] BODY_START = 9'd6;
    localparam logic [8:0] FRAME_OVH  = 9'd7;  // header + check bytes
    localparam logic [8:0] CHECK_OFF  = 9'd5;  // first check byte = L + 5

    localparam int IDX_W = 5;
    localparam int VAL_W = 16;
    localparam int OUT_TDATA_W = 40;

    typedef struct packed {
        logic known;
        logic word;               // 16-bit little-endian values
        logic [IDX_W-1:0] count;  // values per frame
        logic [IDX_W-1:0] max_off;// highest frame offset read
    } cmd_info_t;

    // Controller -> datapath
    typedef struct packed {
        logic load_dev;
        logic load_len;
        logic load_cmd;
        logic body_wr;
        logic emit_start;
        logic rd_hi;
        logic latch_lo;
        logic load_out;
        logic next_index;
    } ctl_cmd_t;

    // Datapath -> controller
    typedef struct packed {
        logic is_sync1;
        logic is_sync2;
        logic is_zero;
        logic frame_done;
        logic cmd_ok;
        logic last;
    } dp_stat_t;

    function automatic cmd_info_t cmd_info(input logic [7:0] cmd);
        cmd_info_t ci;
        ci = '0;
        ci.known = 1'b1;
        case (cmd)
            CMD_POS1: begin
                ci.word = 1'b1; ci.count = 5'd1; ci.max_off = 5'd8;
            end
            CMD_POS10, CMD_VEL10, CMD_CUR10: begin
                ci.word = 1'b1; ci.count = 5'd10; ci.max_off = 5'd25;
            end
            CMD_SENSOR: begin
                ci.count = 5'd25; ci.max_off = 5'd31;
            end
            CMD_ERROR: begin
                ci.count = 5'd2; ci.max_off = 5'd7;
            end
            CMD_TEMP: begin
                ci.count = 5'd10; ci.max_off = 5'd15;
            end
            CMD_VENDOR: begin
                ci.count = 5'd8; ci.max_off = 5'd15;
            end
            default: begin
                ci.known = 1'b0;
            end
        endcase
        return ci;
    endfunction

    // Body index (frame offset - 6) of the low / only byte of value idx
    function automatic logic [IDX_W-1:0] body_lo_index(input logic [7:0] cmd,
                                                       input logic [IDX_W-1:0] idx);
        logic [IDX_W-1:0] r;
        case (cmd)
            CMD_POS1:                      r = 5'd1;
            CMD_POS10, CMD_VEL10, CMD_CUR10: r = {idx[3:0], 1'b0};
            CMD_SENSOR:                    r = idx + 5'd1;
            CMD_VENDOR:                    r = (idx == 5'd0) ? 5'd0 : idx + 5'd2;
            default:                       r = idx;
        endcase
        return r;
    endfunction

endpackage

>>> sv/rfd_datapath.sv
// Datapath of the response frame deframer: frame fields, body memory,
// value assembly and result register. Depends on rfd_pkg.
module rfd_datapath
    import rfd_pkg::*;
(
    input  logic                   aclk,
    input  logic [7:0]             rx_byte,
    input  ctl_cmd_t               cmd,
    output dp_stat_t               stat,
    output logic [OUT_TDATA_W-1:0] out_data,
    output logic                   out_last
);

    logic [7:0]       dev_reg;
    logic [7:0]       len_reg;
    logic [7:0]       cmd_reg;
    logic [8:0]       pos_reg;
    logic [IDX_W-1:0] index_reg;
    logic [7:0]       lo_reg;
    logic [7:0]       rd_data_reg;
    logic [OUT_TDATA_W-1:0] out_data_reg;
    logic             out_last_reg;

    logic [7:0] body_mem [BODY_KEEP];

    cmd_info_t        info;
    logic [8:0]       pos_inc;
    logic [8:0]       store_off;
    logic             store_en;
    logic [IDX_W-1:0] lo_idx;
    logic [IDX_W-1:0] hi_idx;
    logic [BODY_AW-1:0] rd_addr;
    logic [VAL_W-1:0] value;

    assign info      = cmd_info(cmd_reg);
    assign pos_inc   = pos_reg + 9'd1;
    assign store_off = pos_reg - BODY_START;
    assign store_en  = store_off < 9'(BODY_KEEP);
    assign lo_idx    = body_lo_index(cmd_reg, index_reg);
    assign hi_idx    = lo_idx + 5'd1;
    assign rd_addr   = cmd.rd_hi ? BODY_AW'(hi_idx) : BODY_AW'(lo_idx);
    assign value     = info.word ? {rd_data_reg, lo_reg} : {8'h00, lo_reg};

    assign stat.is_sync1   = rx_byte == SYNC1_BYTE;
    assign stat.is_sync2   = rx_byte == SYNC2_BYTE;
    assign stat.is_zero    = rx_byte == ZERO_BYTE;
    assign stat.frame_done = pos_inc >= ({1'b0, len_reg} + FRAME_OVH);
    // data must end before the check bytes
    assign stat.cmd_ok     = info.known &&
                             (({1'b0, len_reg} + CHECK_OFF) > {4'b0, info.max_off});
    assign stat.last       = index_reg == (info.count - 5'd1);

    always_ff @(posedge aclk) begin
        if (cmd.load_dev) dev_reg <= rx_byte;
        if (cmd.load_len) len_reg <= rx_byte;
        if (cmd.load_cmd) begin
            cmd_reg <= rx_byte;
            pos_reg <= BODY_START;
        end else if (cmd.body_wr) begin
            pos_reg <= pos_inc;
        end
        if (cmd.emit_start) index_reg <= '0;
        else if (cmd.next_index) index_reg <= index_reg + 5'd1;
        if (cmd.latch_lo) lo_reg <= rd_data_reg;
        if (cmd.load_out) begin
            out_data_reg <= {3'b000, value, index_reg, dev_reg, cmd_reg};
            out_last_reg <= stat.last;
        end
    end

    // body memory: one write port, one registered read port
    always_ff @(posedge aclk) begin
        if (cmd.body_wr && store_en) body_mem[store_off[BODY_AW-1:0]] <= rx_byte;
        rd_data_reg <= body_mem[rd_addr];
    end

    assign out_data = out_data_reg;
    assign out_last = out_last_reg;

endmodule

>>> sv/rfd_ctrl.sv
// Controller of the response frame deframer: header hunt, body count and
// result sequencing. Depends on rfd_pkg.
module rfd_ctrl
    import rfd_pkg::*;
(
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     in_valid,
    output logic     in_ready,
    output logic     out_valid,
    input  logic     out_ready,
    input  dp_stat_t stat,
    output ctl_cmd_t cmd
);

    typedef enum logic [10:0] {
        ST_SYNC1 = 11'b000_0000_0001,
        ST_SYNC2 = 11'b000_0000_0010,
        ST_DEV   = 11'b000_0000_0100,
        ST_ZERO  = 11'b000_0000_1000,
        ST_LEN   = 11'b000_0001_0000,
        ST_CMD   = 11'b000_0010_0000,
        ST_BODY  = 11'b000_0100_0000,
        ST_RD_LO = 11'b000_1000_0000,
        ST_RD_HI = 11'b001_0000_0000,
        ST_CAP   = 11'b010_0000_0000,
        ST_OUT   = 11'b100_0000_0000
    } state_t;

    state_t state_reg, state_next;
    logic   take;

    assign in_ready  = (state_reg == ST_SYNC1) || (state_reg == ST_SYNC2) ||
                       (state_reg == ST_DEV)   || (state_reg == ST_ZERO)  ||
                       (state_reg == ST_LEN)   || (state_reg == ST_CMD)   ||
                       (state_reg == ST_BODY);
    assign out_valid = state_reg == ST_OUT;
    assign take      = in_valid && in_ready;

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            ST_SYNC1: begin
                if (take && stat.is_sync1) state_next = ST_SYNC2;
            end
            ST_SYNC2: begin
                if (take) begin
                    if (stat.is_sync2) state_next = ST_DEV;
                    else if (!stat.is_sync1) state_next = ST_SYNC1;
                end
            end
            ST_DEV: begin
                if (take) begin
                    cmd.load_dev = 1'b1;
                    state_next   = ST_ZERO;
                end
            end
            ST_ZERO: begin
                if (take) begin
                    if (stat.is_zero) state_next = ST_LEN;
                    else if (stat.is_sync1) state_next = ST_SYNC2;
                    else state_next = ST_SYNC1;
                end
            end
            ST_LEN: begin
                if (take) begin
                    cmd.load_len = 1'b1;
                    state_next   = ST_CMD;
                end
            end
            ST_CMD: begin
                if (take) begin
                    cmd.load_cmd = 1'b1;
                    state_next   = ST_BODY;
                end
            end
            ST_BODY: begin
                if (take) begin
                    cmd.body_wr = 1'b1;
                    if (stat.frame_done) begin
                        if (stat.cmd_ok) begin
                            cmd.emit_start = 1'b1;
                            state_next     = ST_RD_LO;
                        end else begin
                            state_next = ST_SYNC1;
                        end
                    end
                end
            end
            ST_RD_LO: begin
                state_next = ST_RD_HI;
            end
            ST_RD_HI: begin
                cmd.rd_hi    = 1'b1;
                cmd.latch_lo = 1'b1;
                state_next   = ST_CAP;
            end
            ST_CAP: begin
                cmd.load_out = 1'b1;
                state_next   = ST_OUT;
            end
            ST_OUT: begin
                if (out_ready) begin
                    if (stat.last) begin
                        state_next = ST_SYNC1;
                    end else begin
                        cmd.next_index = 1'b1;
                        state_next     = ST_RD_LO;
                    end
                end
            end
            default: begin
                state_next = ST_SYNC1;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) state_reg <= ST_SYNC1;
        else          state_reg <= state_next;
    end

endmodule

>>> sv/response_frame_deframer.sv
// Top level of the response frame deframer: stream ports, controller and
// datapath. Depends on rfd_pkg, rfd_ctrl and rfd_datapath.
//
// Takes one received byte per input request and hunts for the response
// header EE AA <device> 00 <length L> <command>. The frame is L+7 bytes
// long counted from EE; the two trailing check bytes are counted but not
// verified. Bytes from frame offset 6 on are kept in a 32-entry body
// memory. After the last byte of a frame with a known command whose data
// ends before the check bytes, the block sends one output request per
// decoded value (1 to 25 of them), the final one with tlast high; short
// frames and unknown commands produce nothing. A header byte that does not
// match restarts the hunt, and an EE in that place is taken as a new
// first sync byte. Each input byte is taken in one cycle while receiving.
// Each result is built through the single read port of the body memory
// in order: low byte read, high byte read, assembly, presentation; the
// presentation lasts while the sink holds tready low. No byte is taken
// while a frame's results are being sent.
module response_frame_deframer
    import rfd_pkg::*;
(
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   s_tvalid,
    output logic                   s_tready,
    input  logic [7:0]             s_tdata,  // [7:0] rx_byte
    output logic                   m_tvalid,
    input  logic                   m_tready,
    // [7:0] cmd_code, [15:8] device_byte, [20:16] item_index,
    // [36:21] item_value, [39:37] zero
    output logic [OUT_TDATA_W-1:0] m_tdata,
    output logic                   m_tlast   // last_item
);

    ctl_cmd_t ctl;
    dp_stat_t stat;

    rfd_ctrl u_ctrl (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .stat      (stat),
        .cmd       (ctl)
    );

    rfd_datapath u_datapath (
        .aclk     (aclk),
        .rx_byte  (s_tdata),
        .cmd      (ctl),
        .stat     (stat),
        .out_data (m_tdata),
        .out_last (m_tlast)
    );

`ifndef ASSERT_OFF
    // receiving and sending never overlap
    a_no_overlap: assert property (@(posedge aclk) disable iff (!aresetn)
        !(s_tready && m_tvalid))
        else $error("input and output requests active together");

    // the frame's final result ends the burst
    a_last_ends: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tready && m_tlast) |=> (!m_tvalid && s_tready))
        else $error("burst continues after last result");

    // value index stays within the largest frame
    a_index_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata[20:16] <= 5'd24))
        else $error("item index out of range");

    // a non-final result is followed by further results, not by input
    a_more_follow: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tready && !m_tlast) |=> !s_tready)
        else $error("burst cut short");
`endif

endmodule

>>> sim/testbench.sv
// Self-checking bench for response_frame_deframer: byte stream in, decoded values out.
// It walks a table of directed frames, then random frames and noise, and checks each
// value against the table or an in-bench predictor. Needs rfd_pkg and the deframer RTL.
module testbench
    import rfd_pkg::*;
();
    timeunit 1ns;
    timeprecision 1ps;

    localparam int RANDOM_BYTES   = 80;
    localparam int WATCHDOG_LIMIT = 1000;  // cycles with no request on either side
    localparam int DRAIN_CYCLES   = 150;   // longer than a 25-value burst
    localparam int CALM_BYTES     = 30;    // tail of the run without idling

    // command codes outside the decoded set
    localparam logic [7:0] CMD_NONE  = 8'h00;
    localparam logic [7:0] CMD_BOGUS = 8'hFF;

    typedef enum logic [2:0] {
        HUNT_SYNC1, HUNT_SYNC2, HUNT_DEV, HUNT_ZERO, HUNT_LEN, HUNT_CMD, HUNT_BODY
    } hunt_e;

    // bytes placed in front of a frame to disturb the header hunt
    typedef enum {PRE_NONE, PRE_EXTRA_SYNC, PRE_BAD_SYNC2, PRE_SYNC_AT_ZERO, PRE_BAD_ZERO} lead_e;
    typedef enum {FILL_RAND, FILL_ZERO, FILL_ONES, FILL_OFFSET} fill_e;
    // CHK_MODEL: predictor; CHK_NONE: no value; CHK_ONE: the single value in the row
    typedef enum {CHK_MODEL, CHK_NONE, CHK_ONE} chk_e;

    typedef struct {
        lead_e       lead;
        logic [7:0]  dev;
        logic [7:0]  len;
        logic [7:0]  cmd;
        fill_e       fill;
        chk_e        chk;
        logic [15:0] val;
    } frame_row_t;

    typedef struct packed {
        logic [7:0]  cmd;
        logic [7:0]  dev;
        logic [4:0]  idx;
        logic [15:0] val;
        logic        last;
    } frame_value_t;

    logic        aclk     = 1'b0;
    logic        aresetn  = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata  = 8'h00;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [39:0] m_tdata;
    logic        m_tlast;

    // predictor state
    hunt_e       hunt_phase_q = HUNT_SYNC1;
    logic [7:0]  len_q = 8'h00;
    logic [7:0]  cmd_q = 8'h00;
    logic [7:0]  dev_q = 8'h00;
    logic [8:0]  pos_q = 9'd0;
    logic [7:0]  body_q [BODY_KEEP];

    frame_value_t frame_values[$];    // values of the frame just closed
    frame_value_t pending_values[$];  // values still owed by the block

    int errors      = 0;
    int bytes_sent  = 0;
    int idle_pct    = 0;
    bit calm        = 1'b0;
    int sink_stall  = 0;
    int idle_cycles = 0;

    response_frame_deframer DUT (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    // highest frame offset a command reads; 0 for commands that decode nothing
    function automatic int data_reach(input logic [7:0] cmd);
        case (cmd)
            CMD_POS1:                        return 8;
            CMD_POS10, CMD_VEL10, CMD_CUR10: return 25;
            CMD_SENSOR:                      return 31;
            CMD_ERROR:                       return 7;
            CMD_TEMP, CMD_VENDOR:            return 15;
            default:                         return 0;
        endcase
    endfunction

    function automatic int value_count(input logic [7:0] cmd);
        case (cmd)
            CMD_POS1:                        return 1;
            CMD_POS10, CMD_VEL10, CMD_CUR10: return 10;
            CMD_SENSOR:                      return 25;
            CMD_ERROR:                       return 2;
            CMD_TEMP:                        return 10;
            CMD_VENDOR:                      return 8;
            default:                         return 0;
        endcase
    endfunction

    function automatic logic [7:0] body_at(input int off);
        return body_q[off - 6];
    endfunction

    // Advance the predicted deframer by one byte; a closed frame leaves its
    // values in frame_values.
    function automatic void deframe_byte(input logic [7:0] b);
        int          n;
        logic [15:0] v;
        case (hunt_phase_q)
            HUNT_SYNC1: if (b == SYNC1_BYTE) hunt_phase_q = HUNT_SYNC2;
            HUNT_SYNC2: begin
                if (b == SYNC2_BYTE) hunt_phase_q = HUNT_DEV;
                else if (b != SYNC1_BYTE) hunt_phase_q = HUNT_SYNC1;
            end
            HUNT_DEV: begin
                dev_q = b;
                hunt_phase_q = HUNT_ZERO;
            end
            HUNT_ZERO: begin
                // an EE in the zero slot counts as a fresh first sync byte
                if (b == ZERO_BYTE) hunt_phase_q = HUNT_LEN;
                else hunt_phase_q = (b == SYNC1_BYTE) ? HUNT_SYNC2 : HUNT_SYNC1;
            end
            HUNT_LEN: begin
                len_q = b;
                hunt_phase_q = HUNT_CMD;
            end
            HUNT_CMD: begin
                cmd_q = b;
                pos_q = 9'd6;
                hunt_phase_q = HUNT_BODY;
            end
            HUNT_BODY: begin
                if (int'(pos_q) - 6 < BODY_KEEP) body_q[int'(pos_q) - 6] = b;
                pos_q = pos_q + 9'd1;
                if (int'(pos_q) >= int'(len_q) + 7) begin
                    n = value_count(cmd_q);
                    // data must end before the two check bytes at L+5 and L+6
                    if (n > 0 && data_reach(cmd_q) < int'(len_q) + 5) begin
                        for (int i = 0; i < n; i++) begin
                            case (cmd_q)
                                CMD_POS1: v = {body_at(8), body_at(7)};
                                CMD_POS10, CMD_VEL10, CMD_CUR10:
                                    v = {body_at(7 + 2 * i), body_at(6 + 2 * i)};
                                CMD_SENSOR: v = {8'h00, body_at(7 + i)};
                                // model byte, then sw and hw versions, then dof
                                CMD_VENDOR:
                                    v = {8'h00, (i == 0) ? body_at(6) : body_at(8 + i)};
                                default: v = {8'h00, body_at(6 + i)};  // errors, temps
                            endcase
                            frame_values.push_back('{cmd_q, dev_q, 5'(i), v, i == n - 1});
                        end
                    end
                    pos_q = 9'd0;
                    hunt_phase_q = HUNT_SYNC1;
                end
            end
            default: hunt_phase_q = HUNT_SYNC1;
        endcase
    endfunction

    task automatic report_mismatch(input string what, input logic [39:0] got,
                                   input logic [39:0] want);
        $display("MISMATCH at %0t: %s got 0x%0h expected 0x%0h", $time, what, got, want);
        errors++;
    endtask

    // One input request. keep=0 drops the predicted values because the
    // caller types in its own expectation.
    task automatic send_byte(input logic [7:0] b, input bit keep);
        if (!calm && $urandom_range(0, 99) < idle_pct) begin
            s_tvalid <= 1'b0;
            s_tdata  <= 8'($urandom);
            repeat ($urandom_range(1, 9)) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        do @(posedge aclk); while (s_tready !== 1'b1);
        deframe_byte(b);
        if (keep) foreach (frame_values[k]) pending_values.push_back(frame_values[k]);
        frame_values.delete();
        bytes_sent++;
    endtask

    // cut < 0 sends the whole body, otherwise only that many body bytes
    task automatic send_frame(input frame_row_t row, input int cut);
        bit         keep;
        int         body_len;
        logic [7:0] b;
        keep = (row.chk == CHK_MODEL);
        case (row.lead)
            PRE_EXTRA_SYNC: send_byte(SYNC1_BYTE, keep);
            PRE_BAD_SYNC2: begin
                send_byte(SYNC1_BYTE, keep);
                send_byte(8'h55, keep);
            end
            PRE_SYNC_AT_ZERO: begin
                // the frame's own EE then lands in the zero slot
                send_byte(SYNC1_BYTE, keep);
                send_byte(SYNC2_BYTE, keep);
                send_byte(8'h5A, keep);
            end
            PRE_BAD_ZERO: begin
                send_byte(SYNC1_BYTE, keep);
                send_byte(SYNC2_BYTE, keep);
                send_byte(8'h5A, keep);
                send_byte(8'h01, keep);
            end
            default: ;
        endcase
        send_byte(SYNC1_BYTE, keep);
        send_byte(SYNC2_BYTE, keep);
        send_byte(row.dev, keep);
        send_byte(ZERO_BYTE, keep);
        send_byte(row.len, keep);
        send_byte(row.cmd, keep);
        body_len = int'(row.len) + 1;  // offsets 6 .. L+6, check bytes included
        if (cut >= 0 && cut < body_len) body_len = cut;
        for (int off = 6; off < 6 + body_len; off++) begin
            case (row.fill)
                FILL_ZERO:   b = 8'h00;
                FILL_ONES:   b = 8'hFF;
                FILL_OFFSET: b = 8'(off);
                default:     b = 8'($urandom_range(0, 255));
            endcase
            send_byte(b, keep);
        end
        if (row.chk == CHK_ONE) pending_values.push_back('{row.cmd, row.dev, 5'd0, row.val, 1'b1});
    endtask

    // Directed frames; every row starts with the hunt waiting for EE.
    frame_row_t directed_rows [23] = '{
        '{PRE_NONE, 8'h00, 8'd4,   CMD_POS1,   FILL_ZERO,   CHK_ONE,   16'h0000},
        '{PRE_NONE, 8'hFF, 8'd4,   CMD_POS1,   FILL_ONES,   CHK_ONE,   16'hFFFF},
        '{PRE_NONE, 8'h11, 8'd3,   CMD_POS1,   FILL_RAND,   CHK_NONE,  16'h0000},
        '{PRE_NONE, 8'h01, 8'd21,  CMD_POS10,  FILL_OFFSET, CHK_MODEL, 16'h0000},
        '{PRE_NONE, 8'h02, 8'd20,  CMD_VEL10,  FILL_RAND,   CHK_NONE,  16'h0000},
        '{PRE_NONE, 8'h03, 8'd21,  CMD_VEL10,  FILL_ONES,   CHK_MODEL, 16'h0000},
        '{PRE_NONE, 8'h04, 8'd24,  CMD_CUR10,  FILL_RAND,   CHK_MODEL, 16'h0000},
        '{PRE_NONE, 8'h05, 8'd27,  CMD_SENSOR, FILL_OFFSET, CHK_MODEL, 16'h0000},
        '{PRE_NONE, 8'h06, 8'd26,  CMD_SENSOR, FILL_RAND,   CHK_NONE,  16'h0000},
        '{PRE_NONE, 8'h07, 8'd3,   CMD_ERROR,  FILL_OFFSET, CHK_MODEL, 16'h0000},
        '{PRE_NONE, 8'h08, 8'd2,   CMD_ERROR,  FILL_RAND,   CHK_NONE,  16'h0000},
        '{PRE_NONE, 8'h09, 8'd11,  CMD_TEMP,   FILL_RAND,   CHK_MODEL, 16'h0000},
        '{PRE_NONE, 8'h0A, 8'd11,  CMD_VENDOR, FILL_OFFSET, CHK_MODEL, 16'h0000},
        '{PRE_NONE, 8'h0B, 8'd10,  CMD_VENDOR, FILL_RAND,   CHK_NONE,  16'h0000},
        '{PRE_NONE, 8'h0C, 8'd5,   CMD_NONE,   FILL_RAND,   CHK_NONE,  16'h0000},
        '{PRE_NONE, 8'h0D, 8'd5,   CMD_BOGUS,  FILL_RAND,   CHK_NONE,  16'h0000},
        '{PRE_NONE, 8'h0E, 8'd0,   CMD_POS1,   FILL_RAND,   CHK_NONE,  16'h0000},
        // long frame: body bytes past the store are only counted
        '{PRE_NONE, 8'hA5, 8'd33,  CMD_SENSOR, FILL_RAND,   CHK_MODEL, 16'h0000},
        // header disturbances
        '{PRE_EXTRA_SYNC,   8'h5A, 8'd4,  CMD_POS1,   FILL_ONES, CHK_ONE,   16'hFFFF},
        '{PRE_BAD_SYNC2,    8'hEE, 8'd3,  CMD_ERROR,  FILL_RAND, CHK_MODEL, 16'h0000},
        '{PRE_SYNC_AT_ZERO, 8'hAA, 8'd11, CMD_TEMP,   FILL_RAND, CHK_MODEL, 16'h0000},
        '{PRE_BAD_ZERO,     8'h00, 8'd21, CMD_CUR10,  FILL_RAND, CHK_MODEL, 16'h0000},
        '{PRE_NONE,         8'hEE, 8'd15, CMD_VENDOR, FILL_ONES, CHK_MODEL, 16'h0000}
    };

    logic [7:0] decoded_cmds [8] = '{CMD_POS1, CMD_POS10, CMD_VEL10, CMD_CUR10,
                                     CMD_SENSOR, CMD_ERROR, CMD_TEMP, CMD_VENDOR};

    initial begin
        frame_row_t row;
        int         target;
        int         r;
        int         reach;
        int         len_pick;
        int         cut;
        logic [7:0] b;

        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;

        idle_pct = 30;
        foreach (directed_rows[i]) send_frame(directed_rows[i], -1);

        // random frames, mostly well formed, with noise and cut-off frames mixed in
        target = bytes_sent + RANDOM_BYTES;
        while (bytes_sent < target) begin
            calm = (bytes_sent > target - CALM_BYTES);
            if ($urandom_range(0, 9) == 0) begin
                case ($urandom_range(0, 3))
                    0:       idle_pct = 0;
                    1:       idle_pct = 10;
                    2:       idle_pct = 30;
                    default: idle_pct = 60;
                endcase
            end
            r = $urandom_range(0, 99);
            if (r < 12) begin
                repeat ($urandom_range(1, 8)) begin
                    case ($urandom_range(0, 3))
                        0:       b = SYNC1_BYTE;
                        1:       b = SYNC2_BYTE;
                        2:       b = ZERO_BYTE;
                        default: b = 8'($urandom);
                    endcase
                    send_byte(b, 1'b1);
                end
            end else begin
                row.lead = (r < 25) ? lead_e'($urandom_range(1, 4)) : PRE_NONE;
                row.dev  = 8'($urandom);
                row.cmd  = ($urandom_range(0, 6) == 0) ? 8'($urandom)
                                                        : decoded_cmds[$urandom_range(0, 7)];
                reach = data_reach(row.cmd);
                r = $urandom_range(0, 99);
                if (r < 3) len_pick = $urandom_range(0, 255);
                else if (r < 25 || reach == 0) len_pick = $urandom_range(0, 48);
                else len_pick = reach - 6 + $urandom_range(0, 6);  // around the short limit
                row.len = 8'(len_pick);
                case ($urandom_range(0, 9))
                    0:       row.fill = FILL_ZERO;
                    1:       row.fill = FILL_ONES;
                    default: row.fill = FILL_RAND;
                endcase
                row.chk = CHK_MODEL;
                row.val = 16'h0000;
                cut = ($urandom_range(0, 19) == 0) ? $urandom_range(0, len_pick) : -1;
                send_frame(row, cut);
            end
        end
        s_tvalid <= 1'b0;

        while (pending_values.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (errors == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

    // sink side: random stall bursts of random length
    always @(posedge aclk) begin
        if (sink_stall > 0) begin
            sink_stall <= sink_stall - 1;
            m_tready   <= 1'b0;
        end else if (!calm && $urandom_range(0, 99) < idle_pct) begin
            sink_stall <= $urandom_range(0, 8);
            m_tready   <= 1'b0;
        end else begin
            m_tready <= 1'b1;
        end
    end

    // result checker: each output request against the oldest owed value
    always @(posedge aclk) begin
        frame_value_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (pending_values.size() == 0) begin
                report_mismatch("result with none expected", m_tdata, 40'd0);
            end else begin
                want = pending_values.pop_front();
                if (m_tdata[7:0] !== want.cmd)
                    report_mismatch("cmd_code", m_tdata[7:0], want.cmd);
                if (m_tdata[15:8] !== want.dev)
                    report_mismatch("device_byte", m_tdata[15:8], want.dev);
                if (m_tdata[20:16] !== want.idx)
                    report_mismatch("item_index", m_tdata[20:16], want.idx);
                if (m_tdata[36:21] !== want.val)
                    report_mismatch("item_value", m_tdata[36:21], want.val);
                if (m_tdata[39:37] !== 3'b000)
                    report_mismatch("tdata padding", m_tdata[39:37], 40'd0);
                if (m_tlast !== want.last)
                    report_mismatch("last_item", m_tlast, want.last);
            end
        end
    end

    // watchdog: too long without any request on either side
    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("*** FAILED ***");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

endmodule

>>> files.f
sv/rfd_pkg.sv
sv/rfd_datapath.sv
sv/rfd_ctrl.sv
sv/response_frame_deframer.sv
sim/testbench.sv
